// ----- sv/ps2a_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the ps/2 keyboard to character decoder
package ps2a_pkg;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_WRITE  = 2'd1,
		OP_DONE   = 2'd2
	} opcode_t;

	localparam logic [7:0] CODE_EXTENDED = 8'hE0;
	localparam logic [7:0] CODE_RELEASE  = 8'hF0;
	localparam logic [7:0] CODE_SHIFT    = 8'h12;
	localparam logic [7:0] CODE_CTRL     = 8'h14;
	localparam logic [7:0] CODE_ALT_A    = 8'h11;
	localparam logic [7:0] CODE_ALT_B    = 8'h1F;
	localparam logic [7:0] CODE_CAPS     = 8'h58;
	localparam logic [3:0] FRAME_BITS    = 4'd9;

	localparam int IDX_W  = 9;
	localparam int CHAR_W = 8;

	// table lookup request handed from the decoder to the lookup stage
	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  index;
		logic              in_range;
		logic              caps;
		logic              ctrl;
		logic              alt;
	} lookup_req_t;

endpackage

// ----- sv/ps2_keyboard_to_ascii_core.sv -----
`timescale 1ns / 1ps
// top level of the ps/2 keyboard to character decoder
//
// usage
//  input channel: one item per poll of the ps/2 pins (opcode sample, with
//   clock_line and data_line), a table write (opcode write, entry_index and
//   entry_value), or a host transfer done (opcode done, clears busy)
//  an item is taken at a clock edge with in_valid high and in_stall low
//  output channel: character with out_valid, taken when out_stall is low
//  throughput: one item per clock while in_stall is low, every opcode
//  path: the sample that completes a key-press frame sends its code through
//   the lookup stage, which reads the table memory, then into the output
//   register, where caps, ctrl and alt are applied
//  only key presses arriving while the host is not busy make a character;
//   later ones are dropped until a transfer done item arrives
//  stall: a character waiting on out_stall does not block input; in_stall
//   rises only when a second character has been read from the table and
//   both the lookup stage and the output register are full
//  reset: arst_n clears receiver, modifier and busy state and both valid
//   flags; the table is not cleared and must be loaded before use
//  TIMEOUT_POLLS sets the number of samples without an edge that drops a
//   partial frame; TABLE_DEPTH sets the table size (two entries per code)
module ps2_keyboard_to_ascii_core import ps2a_pkg::*; #(
	parameter int TIMEOUT_POLLS = 255,
	parameter int TABLE_DEPTH   = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic              clock_line,
	input  logic              data_line,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [CHAR_W-1:0] entry_value,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAR_W-1:0] character
);

	logic        accept;
	logic        sample;
	logic        wr_en;
	logic        done;
	logic        frame;
	logic [7:0]  code;
	logic        hold;
	lookup_req_t req;

	// item handshake and opcode decode
	assign accept   = in_valid && !in_stall;
	assign in_stall = hold;
	assign sample   = accept && (opcode == OP_SAMPLE);
	assign wr_en    = accept && (opcode == OP_WRITE);
	assign done     = accept && (opcode == OP_DONE);

	// bit-level reception of the ps/2 frame
	ps2a_rx #(
		.TIMEOUT_POLLS(TIMEOUT_POLLS)
	) u_rx (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.clock_line(clock_line),
		.data_line (data_line),
		.frame     (frame),
		.code      (code)
	);

	// scan code interpretation and busy tracking
	ps2a_decode #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_decode (
		.clk   (clk),
		.arst_n(arst_n),
		.frame (frame),
		.code  (code),
		.done  (done),
		.req   (req)
	);

	// table read, modifiers and output register
	ps2a_lookup #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (entry_index),
		.wr_value (entry_value),
		.req      (req),
		.out_stall(out_stall),
		.hold     (hold),
		.character(character),
		.out_valid(out_valid)
	);

	// input is held off only behind a waiting character
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall) else $error("input stalled without cause");

endmodule

// ----- sv/ps2a_rx.sv -----
`timescale 1ns / 1ps
// ps/2 frame receiver: edge detection on polled samples, timeout, bit shifting
module ps2a_rx import ps2a_pkg::*; #(
	parameter int TIMEOUT_POLLS = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample,
	input  logic       clock_line,
	input  logic       data_line,
	output logic       frame,
	output logic [7:0] code
);

	localparam int PW = $clog2(TIMEOUT_POLLS + 1);

	logic          phase_q;    // 0 waiting for falling edge, 1 waiting for rising edge
	logic [PW-1:0] poll_q;
	logic [3:0]    bit_q;
	logic [7:0]    shift_q;

	logic          edge_seen;
	logic [PW-1:0] poll_inc;
	logic          timeout;

	assign edge_seen = phase_q ? clock_line : !clock_line;
	assign poll_inc  = poll_q + PW'(1);
	assign timeout   = poll_inc >= PW'(TIMEOUT_POLLS);
	assign frame     = sample && phase_q && clock_line && (bit_q == FRAME_BITS);
	assign code      = shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			poll_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
		end else if (sample) begin
			if (edge_seen) begin
				poll_q  <= '0;
				phase_q <= !phase_q;
				if (!phase_q) begin
					shift_q <= {data_line, shift_q[7:1]};
					bit_q   <= bit_q + 4'd1;
				end else if (bit_q == FRAME_BITS) begin
					bit_q <= '0;
				end
			end else if (timeout) begin
				poll_q  <= '0;
				bit_q   <= '0;
				phase_q <= 1'b0;
			end else begin
				poll_q <= poll_inc;
			end
		end
	end

	// a frame never holds more than nine bits
	a_bit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= FRAME_BITS) else $error("bit count beyond frame length");

	// a frame completes only on a rising edge
	a_frame_phase: assert property (@(posedge clk) disable iff (!arst_n)
		frame |=> !phase_q && bit_q == 4'd0) else $error("frame end left receiver unsettled");

endmodule

// ----- sv/ps2a_decode.sv -----
`timescale 1ns / 1ps
// scan code decoder: release prefix, modifier keys, caps lock, host busy
module ps2a_decode import ps2a_pkg::*; #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame,
	input  logic [7:0]  code,
	input  logic        done,
	output lookup_req_t req
);

	logic release_q;
	logic shift_q;
	logic ctrl_q;
	logic alt_q;
	logic caps_q;
	logic busy_q;

	logic             plain_key;
	logic             press;
	logic [IDX_W-1:0] index;

	assign plain_key = (code != CODE_EXTENDED) && (code != CODE_RELEASE)
		&& (code != CODE_SHIFT) && (code != CODE_CTRL) && (code != CODE_ALT_A)
		&& (code != CODE_ALT_B) && (code != CODE_CAPS);
	assign press = frame && plain_key && !release_q;
	assign index = {code, shift_q};

	always_comb begin
		req.valid    = press && !busy_q;
		req.index    = index;
		req.in_range = {1'b0, index} < (IDX_W + 1)'(TABLE_DEPTH);
		req.caps     = caps_q;
		req.ctrl     = ctrl_q;
		req.alt      = alt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_q <= 1'b0;
			shift_q   <= 1'b0;
			ctrl_q    <= 1'b0;
			alt_q     <= 1'b0;
			caps_q    <= 1'b0;
			busy_q    <= 1'b0;
		end else begin
			if (done) begin
				busy_q <= 1'b0;
			end
			if (frame) begin
				case (code)
					CODE_EXTENDED: ;
					CODE_RELEASE:  release_q <= 1'b1;
					CODE_SHIFT: begin
						shift_q   <= !release_q;
						release_q <= 1'b0;
					end
					CODE_CTRL: begin
						ctrl_q    <= !release_q;
						release_q <= 1'b0;
					end
					CODE_ALT_A, CODE_ALT_B: begin
						alt_q     <= !release_q;
						release_q <= 1'b0;
					end
					CODE_CAPS: begin
						if (!release_q) begin
							caps_q <= !caps_q;
						end
						release_q <= 1'b0;
					end
					default: begin
						release_q <= 1'b0;
						if (!release_q) begin
							busy_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	// busy is only ever raised by a character handed on
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(req.valid)) else $error("busy set without a character");

endmodule

// ----- sv/ps2a_lookup.sv -----
`timescale 1ns / 1ps
// character table memory, modifier application and output register
module ps2a_lookup import ps2a_pkg::*; #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [CHAR_W-1:0] wr_value,
	input  lookup_req_t       req,
	input  logic              out_stall,
	output logic              hold,
	output logic [CHAR_W-1:0] character,
	output logic              out_valid
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [CHAR_W-1:0] mem [TABLE_DEPTH];

	logic [CHAR_W-1:0] rd_s1;
	lookup_req_t       req_s1;
	logic              valid_s1;
	logic [CHAR_W-1:0] char_q;
	logic              out_valid_q;

	logic              out_take;
	logic              wr_in_range;
	logic [CHAR_W-1:0] raw;
	logic [CHAR_W-1:0] mod;

	assign out_take    = !out_valid_q || !out_stall;
	assign hold        = valid_s1 && !out_take;
	assign wr_in_range = {1'b0, wr_index} < (IDX_W + 1)'(TABLE_DEPTH);
	assign character   = char_q;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en && wr_in_range) begin
			mem[wr_index[AW-1:0]] <= wr_value;
		end
		if (req.valid) begin
			rd_s1  <= mem[req.index[AW-1:0]];
			req_s1 <= req;
		end
	end

	always_comb begin
		raw = req_s1.in_range ? rd_s1 : '0;
		mod = raw;
		if (req_s1.caps && mod >= 8'h61 && mod <= 8'h7A) begin
			mod = mod & 8'hDF;
		end
		if (req_s1.ctrl) begin
			mod = mod & 8'h1F;
		end
		if (req_s1.alt && mod != 8'h00) begin
			mod = mod | 8'h80;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.valid) begin
				valid_s1 <= 1'b1;
			end else if (out_take) begin
				valid_s1 <= 1'b0;
			end
			if (out_take) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && valid_s1) begin
			char_q <= mod;
		end
	end

	// a new lookup never lands on a stage that is still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> !hold) else $error("lookup stage overrun");

endmodule

// ----- tb/ps2_keyboard_to_ascii_core_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the ps/2 keyboard to character decoder
module ps2_keyboard_to_ascii_core_tb;
	import ps2a_pkg::*;

	localparam int TIMEOUT_POLLS = 255;
	localparam int TABLE_DEPTH   = 512;
	localparam int RESET_CYCLES  = 11;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_REPORTS   = 40;
	localparam longint LIMIT_NS  = 64'd6_000_000;

	// opcode with no function, must leave every piece of state alone
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// character values used by the modifier rules
	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_ALL     = 8'hFF;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CASE_BIT     = 8'h20;
	localparam logic [7:0] CTRL_KEEP    = 8'h1F;
	localparam logic [7:0] ALT_BIT      = 8'h80;

	// scan codes for the directed part
	localparam logic [7:0] KEY_A    = 8'h1C;
	localparam logic [7:0] KEY_LOW  = 8'h00;
	localparam logic [7:0] KEY_HIGH = 8'hFF;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [1:0]        opcode      = OP_SAMPLE;
	logic              clock_line  = 1'b1;
	logic              data_line   = 1'b1;
	logic [IDX_W-1:0]  entry_index = '0;
	logic [CHAR_W-1:0] entry_value = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [CHAR_W-1:0] character;

	// keyboard state as the block should hold it
	logic        rise_wait    = 1'b0;
	int unsigned poll_run     = 0;
	logic [3:0]  frame_bits   = '0;
	logic [7:0]  frame_reg    = '0;
	logic        release_seen = 1'b0;
	logic        shift_down   = 1'b0;
	logic        ctrl_down    = 1'b0;
	logic        alt_down     = 1'b0;
	logic        caps_on      = 1'b0;
	logic        host_busy    = 1'b0;
	logic [7:0]  char_map [TABLE_DEPTH];
	logic [7:0]  expected_chars [$];
	logic [7:0]  char_want;

	// sender and receiver pacing
	bit gaps_on        = 1'b0;
	int burst_left     = 0;
	int frame_jitter   = 0;
	bit mix_side_items = 1'b0;
	int stall_pct      = 0;
	int stall_run      = 0;
	bit hold_req       = 1'b0;
	int hold_left      = 0;

	// run statistics
	int items_sent      = 0;
	int samples_sent    = 0;
	int writes_sent     = 0;
	int dones_sent      = 0;
	int unused_sent     = 0;
	int chars_expected  = 0;
	int chars_checked   = 0;
	int chars_dropped   = 0;
	int timeouts_seen   = 0;
	int in_stall_cycles = 0;
	int error_count     = 0;

	ps2_keyboard_to_ascii_core #(
		.TIMEOUT_POLLS(TIMEOUT_POLLS),
		.TABLE_DEPTH  (TABLE_DEPTH)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.clock_line (clock_line),
		.data_line  (data_line),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.character  (character)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// a sample without the awaited edge; a long enough run drops the partial frame
	function automatic void count_poll();
		poll_run++;
		if (poll_run >= TIMEOUT_POLLS) begin
			poll_run   = 0;
			frame_bits = '0;
			rise_wait  = 1'b0;
			timeouts_seen++;
		end
	endfunction

	// one complete scan code: prefixes, modifiers, or a key that looks up the table
	function automatic void decode_scan_code(input logic [7:0] code);
		logic [8:0] slot;
		logic [7:0] ch;
		if (code == CODE_EXTENDED)
			return;
		if (code == CODE_RELEASE) begin
			release_seen = 1'b1;
			return;
		end
		if (code == CODE_SHIFT) begin
			shift_down = !release_seen;
		end else if (code == CODE_CTRL) begin
			ctrl_down = !release_seen;
		end else if (code == CODE_ALT_A || code == CODE_ALT_B) begin
			alt_down = !release_seen;
		end else if (code == CODE_CAPS) begin
			if (!release_seen)
				caps_on = !caps_on;
		end else if (!release_seen) begin
			// two columns per code, the second one for shift
			slot = {code, shift_down};
			ch = (int'(slot) < TABLE_DEPTH) ? char_map[slot] : CHAR_NUL;
			if (caps_on && ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
				ch = ch & ~CASE_BIT;
			if (ctrl_down)
				ch = ch & CTRL_KEEP;
			if (alt_down && ch != CHAR_NUL)
				ch = ch | ALT_BIT;
			release_seen = 1'b0;
			if (host_busy) begin
				chars_dropped++;
				return;
			end
			host_busy = 1'b1;
			expected_chars.push_back(ch);
			chars_expected++;
			return;
		end
		release_seen = 1'b0;
	endfunction

	// advance the expected state by one accepted item
	function automatic void track_item(input logic [1:0] op, input logic cl, input logic dl,
			input logic [8:0] idx, input logic [7:0] val);
		items_sent++;
		if (op == OP_WRITE) begin
			writes_sent++;
			if (int'(idx) < TABLE_DEPTH)
				char_map[idx] = val;
		end else if (op == OP_DONE) begin
			dones_sent++;
			host_busy = 1'b0;
		end else if (op == OP_SAMPLE) begin
			samples_sent++;
			if (!rise_wait) begin
				if (!cl) begin
					// falling edge: shift in lsb first
					frame_reg  = {dl, frame_reg[7:1]};
					frame_bits = frame_bits + 4'd1;
					poll_run   = 0;
					rise_wait  = 1'b1;
				end else begin
					count_poll();
				end
			end else if (cl) begin
				poll_run  = 0;
				rise_wait = 1'b0;
				// the rise after the ninth fall closes the frame
				if (frame_bits == FRAME_BITS) begin
					frame_bits = '0;
					decode_scan_code(frame_reg);
				end
			end else begin
				count_poll();
			end
		end else begin
			unused_sent++;
		end
	endfunction

	// offer one item, hold it until taken, then maybe pause between bursts
	task automatic send_item(input logic [1:0] op, input logic cl, input logic dl,
			input logic [8:0] idx, input logic [7:0] val);
		int gap;
		in_valid    <= 1'b1;
		opcode      <= op;
		clock_line  <= cl;
		data_line   <= dl;
		entry_index <= idx;
		entry_value <= val;
		@(negedge clk);
		while (in_stall !== 1'b0)
			@(negedge clk);
		track_item(op, cl, dl, idx, val);
		@(posedge clk);
		if (gaps_on) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// unused fields carry random values so that their bits get exercised
	task automatic send_sample(input logic cl, input logic dl);
		send_item(OP_SAMPLE, cl, dl, 9'($urandom), 8'($urandom));
	endtask

	task automatic send_done();
		send_item(OP_DONE, 1'($urandom), 1'($urandom), 9'($urandom), 8'($urandom));
	endtask

	// mostly lower-case letters so that caps has something to do
	function automatic logic [7:0] pick_char_value();
		case ($urandom_range(0, 9))
			0: return CHAR_NUL;
			1: return CHAR_ALL;
			2, 3: return 8'($urandom);
			default: return 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
		endcase
	endfunction

	function automatic logic [7:0] pick_plain_code();
		logic [7:0] c;
		do
			c = 8'($urandom);
		while (c == CODE_EXTENDED || c == CODE_RELEASE || c == CODE_SHIFT || c == CODE_CTRL ||
			c == CODE_ALT_A || c == CODE_ALT_B || c == CODE_CAPS);
		return c;
	endfunction

	// a non-sample item: table write, transfer done or the unused opcode
	task automatic send_side_item();
		case ($urandom_range(0, 2))
			0: send_done();
			1: send_item(OP_WRITE, 1'($urandom), 1'($urandom), 9'($urandom), pick_char_value());
			default: send_item(OP_UNUSED, 1'($urandom), 1'($urandom), 9'($urandom), 8'($urandom));
		endcase
	endtask

	// start bit plus eight data bits, clock held a few extra polls per level
	task automatic send_frame(input logic [7:0] code);
		logic [8:0] frame;
		int i;
		frame = {code, 1'($urandom)};
		for (i = 0; i < 9; i++) begin
			if (mix_side_items && $urandom_range(0, 31) == 0)
				send_side_item();
			send_sample(1'b0, frame[i]);
			repeat ($urandom_range(0, frame_jitter)) send_sample(1'b0, 1'($urandom));
			send_sample(1'b1, 1'($urandom));
			repeat ($urandom_range(0, frame_jitter)) send_sample(1'b1, 1'($urandom));
		end
	endtask

	task automatic release_key(input logic [7:0] code);
		send_frame(CODE_RELEASE);
		send_frame(code);
	endtask

	task automatic send_bit_pairs(input int n);
		repeat (n) begin
			send_sample(1'b0, 1'($urandom));
			send_sample(1'b1, 1'($urandom));
		end
	endtask

	// finish whatever partial frame is in flight with random bits
	task automatic resync_frame();
		while (frame_bits != 0 || rise_wait)
			send_sample(rise_wait, 1'($urandom));
	endtask

	// sender goes quiet until every character in flight has been taken
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
	endtask

	// fill every table entry, nul at the bottom and all ones at the top
	task automatic test_table_load();
		int i;
		for (i = 0; i < TABLE_DEPTH; i++)
			send_item(OP_WRITE, 1'($urandom), 1'($urandom), 9'(i),
				(i == 0) ? CHAR_NUL : (i == TABLE_DEPTH - 1) ? CHAR_ALL : pick_char_value());
	endtask

	task automatic test_directed_keys();
		frame_jitter   = 0;
		mix_side_items = 1'b0;
		send_item(OP_WRITE, 1'b0, 1'b0, {KEY_A, 1'b0}, CHAR_LOWER_A);
		send_item(OP_WRITE, 1'b1, 1'b1, {KEY_A, 1'b1}, CHAR_UPPER_A);
		// plain press, then the shift column
		send_frame(KEY_A);
		send_done();
		send_frame(CODE_SHIFT);
		send_frame(KEY_A);
		send_done();
		release_key(CODE_SHIFT);
		// caps on: lower case goes up, release of caps does not toggle
		send_frame(CODE_CAPS);
		release_key(CODE_CAPS);
		send_frame(KEY_A);
		send_done();
		send_frame(CODE_SHIFT);
		send_frame(KEY_A);
		send_done();
		release_key(CODE_SHIFT);
		send_frame(CODE_CAPS);
		// ctrl keeps the low five bits
		send_frame(CODE_CTRL);
		send_frame(KEY_A);
		send_done();
		release_key(CODE_CTRL);
		// both alt codes; a nul character stays nul
		send_frame(CODE_ALT_A);
		send_frame(KEY_A);
		send_done();
		release_key(CODE_ALT_A);
		send_frame(CODE_ALT_B);
		send_frame(KEY_LOW);
		send_done();
		send_frame(KEY_A);
		send_done();
		release_key(CODE_ALT_B);
		// top entry of the table
		send_frame(CODE_SHIFT);
		send_frame(KEY_HIGH);
		send_done();
		release_key(CODE_SHIFT);
		// a second press while the host is busy is dropped
		send_frame(KEY_A);
		send_frame(KEY_A);
		send_done();
		send_frame(KEY_A);
		send_done();
		// releases and the extended prefix make nothing on their own
		release_key(KEY_A);
		send_frame(CODE_EXTENDED);
		send_frame(KEY_A);
		send_done();
		send_frame(CODE_EXTENDED);
		release_key(KEY_A);
		send_item(OP_UNUSED, 1'b1, 1'b1, '1, '1);
	endtask

	task automatic test_frame_timeout();
		frame_jitter   = 1;
		mix_side_items = 1'b0;
		// one poll short of the limit keeps the partial frame
		send_bit_pairs(4);
		repeat (TIMEOUT_POLLS - 1) send_sample(1'b1, 1'($urandom));
		resync_frame();
		send_done();
		// idle clock for the full limit drops it
		send_bit_pairs(3);
		repeat (TIMEOUT_POLLS) send_sample(1'b1, 1'($urandom));
		send_frame(KEY_A);
		send_done();
		// clock stuck low: after the drop a low sample is a new falling edge
		send_bit_pairs(2);
		send_sample(1'b0, 1'($urandom));
		repeat (TIMEOUT_POLLS) send_sample(1'b0, 1'($urandom));
		send_sample(1'b0, 1'($urandom));
		resync_frame();
		send_done();
		// drop right after the ninth falling edge, so no code comes out
		send_bit_pairs(8);
		send_sample(1'b0, 1'($urandom));
		repeat (TIMEOUT_POLLS) send_sample(1'b0, 1'($urandom));
		send_sample(1'b1, 1'($urandom));
		send_frame(KEY_A);
		send_done();
	endtask

	// receiver holds off while key presses keep coming, until input stalls
	task automatic test_back_pressure();
		gaps_on        = 1'b0;
		frame_jitter   = 0;
		mix_side_items = 1'b0;
		send_done();
		hold_req = 1'b1;
		repeat (5) begin
			send_frame(KEY_A);
			send_done();
		end
		wait_for_drain();
	endtask

	// well-formed key traffic with random content, plus noise and broken frames
	task automatic test_random_traffic(input int min_items, input int min_chars,
			input int pct, input bit gaps);
		int items0;
		int chars0;
		int r;
		logic [7:0] code;
		stall_pct      = pct;
		gaps_on        = gaps;
		mix_side_items = 1'b1;
		items0 = items_sent - unused_sent;
		chars0 = chars_expected;
		while (items_sent - unused_sent - items0 < min_items || chars_expected - chars0 < min_chars) begin
			frame_jitter = ($urandom_range(0, 9) == 0) ? 20 : 2;
			r = $urandom_range(0, 99);
			if (r < 35) begin
				send_frame(pick_plain_code());
				if ($urandom_range(0, 4) != 0)
					send_done();
			end else if (r < 47) begin
				release_key(($urandom_range(0, 3) == 0) ? 8'($urandom) : pick_plain_code());
			end else if (r < 60) begin
				case ($urandom_range(0, 3))
					0: code = CODE_SHIFT;
					1: code = CODE_CTRL;
					2: code = CODE_ALT_A;
					default: code = CODE_ALT_B;
				endcase
				if ($urandom_range(0, 1))
					send_frame(CODE_RELEASE);
				send_frame(code);
			end else if (r < 65) begin
				send_frame(CODE_CAPS);
				if ($urandom_range(0, 1))
					release_key(CODE_CAPS);
			end else if (r < 70) begin
				send_frame(CODE_EXTENDED);
				if ($urandom_range(0, 1))
					send_frame(CODE_RELEASE);
				send_frame(pick_plain_code());
			end else if (r < 82) begin
				send_side_item();
			end else if (r < 90) begin
				// line noise, usually followed by a completed frame to get back in step
				repeat ($urandom_range(1, 8)) send_sample(1'($urandom), 1'($urandom));
				if ($urandom_range(0, 4) != 0)
					resync_frame();
			end else begin
				send_frame(8'($urandom));
			end
		end
	endtask

	// receiver stall pattern: runs of random level, or a long hold on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_run > 0) begin
			stall_run--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
			stall_run = $urandom_range(0, 6);
		end
	end

	// compare each character taken from the block with the oldest one expected
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_stall)
				in_stall_cycles++;
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("character %h with none expected", character));
				end else begin
					char_want = expected_chars.pop_front();
					chars_checked++;
					if (character !== char_want)
						report_mismatch($sformatf("character %h, expected %h", character, char_want));
				end
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		stall_pct = 20;
		gaps_on   = 1'b1;
		test_table_load();
		test_directed_keys();
		wait_for_drain();
		test_frame_timeout();
		wait_for_drain();
		test_back_pressure();
		// no idling on either side
		test_random_traffic(400, 16, 0, 1'b0);
		wait_for_drain();
		test_random_traffic(450, 16, 30, 1'b1);
		wait_for_drain();
		test_random_traffic(400, 16, 70, 1'b1);
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_chars.size() != 0)
			report_mismatch($sformatf("%0d characters never came out", expected_chars.size()));
		$display("covered %0d items: %0d line samples, %0d table writes, %0d transfer done, %0d unused",
			items_sent, samples_sent, writes_sent, dones_sent, unused_sent);
		$display("%0d characters checked, %0d dropped while busy, %0d frame drops, %0d input stall cycles",
			chars_checked, chars_dropped, timeouts_seen, in_stall_cycles);
		if (error_count == 0) begin
			$display("PASS ps2_keyboard_to_ascii_core");
		end else begin
			$display("FAIL ps2_keyboard_to_ascii_core");
		end
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#(LIMIT_NS);
		$display("FAIL ps2_keyboard_to_ascii_core");
		$finish;
	end

endmodule
